>>> hw/rtl/dcfm_pkg.sv
// Package for the DTMF carrier FM synthesiser: request codes, tone step tables,
// the quarter-wave sine table and the control struct between the top level and core.
// No dependencies.
package dcfm_pkg;

    // Field widths
    localparam int PeriodW  = 10;
    localparam int CompareW = 9;
    localparam int KeyW     = 5;
    localparam int StepW    = 8;
    localparam int PhaseW   = 16;

    // Carrier period after reset (36 kHz at 16 MHz)
    localparam logic [PeriodW-1:0] CarrierReset = 10'd444;

    // Request kinds carried on tuser
    localparam logic CmdTick   = 1'b0;
    localparam logic CmdSelect = 1'b1;

    // Phase steps per key: round(hz * 2^20 / 16e6)
    // low tones 697/770/852/941 Hz -> 46/50/56/62
    // high tones 1209/1336/1447/1633 Hz -> 79/88/95/107
    localparam logic [StepW-1:0] StepLow [16] = '{
        8'd46, 8'd46, 8'd46, 8'd50, 8'd50, 8'd50, 8'd56, 8'd56,
        8'd56, 8'd62, 8'd62, 8'd62, 8'd46, 8'd50, 8'd56, 8'd62
    };
    localparam logic [StepW-1:0] StepHigh [16] = '{
        8'd79, 8'd88, 8'd95, 8'd79, 8'd88, 8'd95, 8'd79, 8'd88,
        8'd95, 8'd88, 8'd79, 8'd95, 8'd107, 8'd107, 8'd107, 8'd107
    };

    // Quarter wave, round(127 * sin(k*pi/128)) for k = 0..64
    localparam logic [6:0] QuarterMag [65] = '{
        7'd0,   7'd3,   7'd6,   7'd9,   7'd12,  7'd16,  7'd19,  7'd22,
        7'd25,  7'd28,  7'd31,  7'd34,  7'd37,  7'd40,  7'd43,  7'd46,
        7'd49,  7'd51,  7'd54,  7'd57,  7'd60,  7'd63,  7'd65,  7'd68,
        7'd71,  7'd73,  7'd76,  7'd78,  7'd81,  7'd83,  7'd85,  7'd88,
        7'd90,  7'd92,  7'd94,  7'd96,  7'd98,  7'd100, 7'd102, 7'd104,
        7'd106, 7'd107, 7'd109, 7'd111, 7'd112, 7'd113, 7'd115, 7'd116,
        7'd117, 7'd118, 7'd120, 7'd121, 7'd122, 7'd122, 7'd123, 7'd124,
        7'd125, 7'd125, 7'd126, 7'd126, 7'd126, 7'd127, 7'd127, 7'd127,
        7'd127
    };

    // Per-cycle control from the handshake logic to the core
    typedef struct packed {
        logic            tick;
        logic            sel;
        logic [KeyW-1:0] key;
    } dcfm_ctrl_t;

    // Full-wave signed sine from the quarter table, odd symmetry
    function automatic logic signed [7:0] sine_entry(input logic [7:0] idx);
        logic [6:0] qidx;
        logic [6:0] mag;
        qidx = idx[6] ? (7'd64 - {1'b0, idx[5:0]}) : {1'b0, idx[5:0]};
        mag  = QuarterMag[qidx];
        return idx[7] ? -$signed({1'b0, mag}) : $signed({1'b0, mag});
    endfunction

endpackage

>>> hw/rtl/dtmf_carrier_fm_synth.sv
// DTMF carrier FM synthesiser. A tick request gives its result via the input register,
// then the result register. Throughput: one request per cycle, except that a tick stalls
// in the input register while a result waits and m_tready is low. The result register
// decouples output: while a result waits, selects pass and an empty input register fills.
// Reset (rst_n, async, active low): phases and steps zero, carrier and next period 444.
// Top level; depends on dcfm_pkg and dcfm_tone_core.
module dtmf_carrier_fm_synth (
    input  logic                          clk,
    input  logic                          rst_n,
    // carrier_period register
    input  logic                          carrier_we,
    input  logic [dcfm_pkg::PeriodW-1:0]  carrier_wdata,
    // request stream
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [7:0]                    s_tdata,   // [4:0] key, [7:5] zero
    input  logic                          s_tuser,   // [0] cmd
    // result stream
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [23:0]                   m_tdata    // [9:0] period, [18:10] compare_value
);
    import dcfm_pkg::*;

    logic [PeriodW-1:0] carrier_reg;
    logic               in_valid_reg;
    logic               in_cmd_reg;
    logic [KeyW-1:0]    in_key_reg;
    logic               out_valid_reg;
    logic [PeriodW-1:0] out_period_reg;
    logic [PeriodW-1:0] period_now;
    logic               advance;
    dcfm_ctrl_t         ctrl;

    // Input register moves on when selects go, or the result slot frees
    assign advance  = in_valid_reg && (in_cmd_reg == CmdSelect || !out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;

    assign ctrl.tick = advance && (in_cmd_reg == CmdTick);
    assign ctrl.sel  = advance && (in_cmd_reg == CmdSelect);
    assign ctrl.key  = in_key_reg;

    dcfm_tone_core u_core (
        .clk            (clk),
        .rst_n          (rst_n),
        .ctrl           (ctrl),
        .carrier_period (carrier_reg),
        .period_now     (period_now)
    );

    // Configuration register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            carrier_reg <= CarrierReset;
        else if (carrier_we)
            carrier_reg <= carrier_wdata;
    end

    // Input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (s_tready)
            in_valid_reg <= s_tvalid;
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            in_cmd_reg <= s_tuser;
            in_key_reg <= s_tdata[KeyW-1:0];
        end
    end

    // Result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (ctrl.tick)
            out_valid_reg <= 1'b1;
        else if (m_tready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.tick)
            out_period_reg <= period_now;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {5'd0, out_period_reg[PeriodW-1:1], out_period_reg};

endmodule

>>> hw/rtl/dcfm_tone_core.sv
// Tone state and next-period arithmetic: phase accumulators, steps, sine lookup,
// tone weighting and saturation. Depends on dcfm_pkg.
module dcfm_tone_core (
    input  logic                        clk,
    input  logic                        rst_n,
    input  dcfm_pkg::dcfm_ctrl_t        ctrl,
    input  logic [dcfm_pkg::PeriodW-1:0] carrier_period,
    output logic [dcfm_pkg::PeriodW-1:0] period_now
);
    import dcfm_pkg::*;

    logic [PhaseW-1:0]  phase_low_reg,  phase_low_next;
    logic [PhaseW-1:0]  phase_high_reg, phase_high_next;
    logic [StepW-1:0]   step_low_reg,   step_low_next;
    logic [StepW-1:0]   step_high_reg,  step_high_next;
    logic [PeriodW-1:0] next_period_reg, next_period_next;

    logic [15:0]        prod_low, prod_high;
    logic signed [7:0]  mod_lo, mod_hi;
    logic signed [9:0]  hi_w;
    logic signed [9:0]  tone_sum;
    logic signed [9:0]  sum_q;
    logic signed [11:0] np;

    assign period_now = next_period_reg;

    // Step load on select; a key with bit 4 set clears both steps
    always_comb
    begin
        step_low_next  = step_low_reg;
        step_high_next = step_high_reg;
        if (ctrl.sel)
        begin
            if (ctrl.key[4])
            begin
                step_low_next  = '0;
                step_high_next = '0;
            end
            else
            begin
                step_low_next  = StepLow[ctrl.key[3:0]];
                step_high_next = StepHigh[ctrl.key[3:0]];
            end
        end
    end

    // Phase advance by ((period * step) mod 2^16) / 16, then sine and weighting
    always_comb
    begin
        prod_low        = 16'(period_now * step_low_reg);
        prod_high       = 16'(period_now * step_high_reg);
        phase_low_next  = phase_low_reg  + {4'd0, prod_low[15:4]};
        phase_high_next = phase_high_reg + {4'd0, prod_high[15:4]};
        mod_lo          = sine_entry(phase_low_next[15:8]);
        mod_hi          = sine_entry(phase_high_next[15:8]);

        // high tone x2 when step_high/2 > step_low, else h + h/2 toward zero
        if ({1'b0, step_high_reg[7:1]} > step_low_reg)
            hi_w = 10'(mod_hi) <<< 1;
        else
            hi_w = 10'(mod_hi) + ((10'(mod_hi) + $signed({9'd0, mod_hi[7]})) >>> 1);

        tone_sum = 10'(mod_lo) + hi_w;
        // divide by 32 toward zero
        sum_q    = (tone_sum + (tone_sum[9] ? 10'sd31 : 10'sd0)) >>> 5;
        np       = $signed({2'b00, carrier_period}) + 12'(sum_q);

        if (np[11])
            next_period_next = '0;
        else if (np > 12'sd1023)
            next_period_next = '1;
        else
            next_period_next = np[PeriodW-1:0];
    end

    // State registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_low_reg   <= '0;
            phase_high_reg  <= '0;
            step_low_reg    <= '0;
            step_high_reg   <= '0;
            next_period_reg <= CarrierReset;
        end
        else
        begin
            step_low_reg  <= step_low_next;
            step_high_reg <= step_high_next;
            if (ctrl.tick)
            begin
                phase_low_reg   <= phase_low_next;
                phase_high_reg  <= phase_high_next;
                next_period_reg <= next_period_next;
            end
        end
    end

endmodule
